@@ src/pdfs_pkg.sv @@
// ----------------------------------------------------------------------------
// pdfs_pkg
// Shared types and constants of the pulse distance frame sender.
// ----------------------------------------------------------------------------
package pdfs_pkg;

  localparam int unsigned CfgW    = 12;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned DataW   = 16;

  // Register indexes of the configuration port
  localparam logic [CfgIdxW-1:0] REG_SHORT_LOW   = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_HEADER_LOW  = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_HEADER_HIGH = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_ZERO_HIGH   = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_ONE_HIGH    = 3'd4;

  // Reset values of the duration registers
  localparam logic [CfgW-1:0] RST_SHORT_LOW   = 12'd250;
  localparam logic [CfgW-1:0] RST_HEADER_LOW  = 12'd1000;
  localparam logic [CfgW-1:0] RST_HEADER_HIGH = 12'd700;
  localparam logic [CfgW-1:0] RST_ZERO_HIGH   = 12'd750;
  localparam logic [CfgW-1:0] RST_ONE_HIGH    = 12'd1750;

  // Request operation codes
  localparam logic OP_TICK = 1'b0;
  localparam logic OP_LOAD = 1'b1;

  typedef struct packed {
    logic line_level;
    logic busy_res;
    logic accepted;
    logic frame_done;
  } res_t;

endpackage

@@ src/pdfs_in_if.sv @@
// ----------------------------------------------------------------------------
// pdfs_in_if
// Request channel: one tick or one word load per request.
// ----------------------------------------------------------------------------
interface pdfs_in_if;
  logic                       valid;
  logic                       ready;
  logic                       operation;
  logic [pdfs_pkg::DataW-1:0] data_word;

  modport source (output valid, output operation, output data_word, input ready);
  modport sink (input valid, input operation, input data_word, output ready);
endinterface

@@ src/pdfs_out_if.sv @@
// ----------------------------------------------------------------------------
// pdfs_out_if
// Result channel: line level and frame status after each request.
// ----------------------------------------------------------------------------
interface pdfs_out_if;
  logic valid;
  logic ready;
  logic line_level;
  logic busy_res;
  logic accepted;
  logic frame_done;

  modport source (
    output valid, output line_level, output busy_res, output accepted,
    output frame_done, input ready
  );
  modport sink (
    input valid, input line_level, input busy_res, input accepted,
    input frame_done, output ready
  );
endinterface

@@ src/pdfs_res_buf.sv @@
// ----------------------------------------------------------------------------
// pdfs_res_buf
// Two-entry result buffer: output register plus skid register.
// ----------------------------------------------------------------------------
module pdfs_res_buf (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  pdfs_pkg::res_t push_data_i,
  output logic           push_ready_o,
  output logic           pop_valid_o,
  input  logic           pop_ready_i,
  output pdfs_pkg::res_t pop_data_o
);

  logic           main_valid_q, main_valid_d;
  logic           skid_valid_q, skid_valid_d;
  pdfs_pkg::res_t main_q, main_d;
  pdfs_pkg::res_t skid_q, skid_d;
  logic           pop;

  assign pop          = main_valid_q & pop_ready_i;
  assign push_ready_o = ~skid_valid_q;
  assign pop_valid_o  = main_valid_q;
  assign pop_data_o   = main_q;

  always_comb begin
    main_valid_d = main_valid_q;
    skid_valid_d = skid_valid_q;
    main_d       = main_q;
    skid_d       = skid_q;
    if (pop) begin
      if (skid_valid_q) begin
        // promote the waiting result; push is blocked while skid is full
        main_d       = skid_q;
        skid_valid_d = 1'b0;
      end else if (push_i) begin
        main_d = push_data_i;
      end else begin
        main_valid_d = 1'b0;
      end
    end else if (push_i) begin
      if (!main_valid_q) begin
        main_d       = push_data_i;
        main_valid_d = 1'b1;
      end else begin
        skid_d       = push_data_i;
        skid_valid_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      main_valid_q <= main_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    main_q <= main_d;
    skid_q <= skid_d;
  end

endmodule

@@ src/pulse_distance_frame_sender_top.sv @@
// ----------------------------------------------------------------------------
// pulse_distance_frame_sender_top
// Sends a key word as a pulse distance frame on one idle-high line.
// ----------------------------------------------------------------------------
// Result: registered in the result buffer when its request is accepted.
// Throughput: one request per cycle while the skid register is empty; the
//   phase/tick counter update is a single decrement or period load, and a
//   two-entry result buffer keeps requests flowing while one result waits.
// Reset: idle, line high, duration registers at their default values.
// ----------------------------------------------------------------------------
module pulse_distance_frame_sender_top #(
  parameter int unsigned WORD_BITS = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [pdfs_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [pdfs_pkg::CfgW-1:0]    cfg_data_i,
  pdfs_in_if.sink                      in_i,
  pdfs_out_if.source                   out_o
);

  localparam int unsigned PhW = $clog2(2 * WORD_BITS + 5);
  localparam logic [PhW-1:0] GuardPh = PhW'(4 + 2 * WORD_BITS);

  logic [pdfs_pkg::CfgW-1:0] short_low_q, header_low_q, header_high_q;
  logic [pdfs_pkg::CfgW-1:0] zero_high_q, one_high_q;

  logic [PhW-1:0]            phase_q, phase_d, next_ph;
  logic [pdfs_pkg::CfgW-1:0] ticks_q, ticks_d;
  logic [WORD_BITS-1:0]      shift_q, shift_d;
  logic                      sending_q, sending_d;
  logic                      level_q, level_d;
  logic [31:0]               word_ext;

  logic           in_acc;
  logic           buf_ready;
  pdfs_pkg::res_t res;

  assign in_acc   = in_i.valid & buf_ready;
  assign in_i.ready = buf_ready;
  assign word_ext = 32'(in_i.data_word);
  assign next_ph  = phase_q + PhW'(1);

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      short_low_q   <= pdfs_pkg::RST_SHORT_LOW;
      header_low_q  <= pdfs_pkg::RST_HEADER_LOW;
      header_high_q <= pdfs_pkg::RST_HEADER_HIGH;
      zero_high_q   <= pdfs_pkg::RST_ZERO_HIGH;
      one_high_q    <= pdfs_pkg::RST_ONE_HIGH;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        pdfs_pkg::REG_SHORT_LOW:   short_low_q   <= cfg_data_i;
        pdfs_pkg::REG_HEADER_LOW:  header_low_q  <= cfg_data_i;
        pdfs_pkg::REG_HEADER_HIGH: header_high_q <= cfg_data_i;
        pdfs_pkg::REG_ZERO_HIGH:   zero_high_q   <= cfg_data_i;
        pdfs_pkg::REG_ONE_HIGH:    one_high_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    phase_d   = phase_q;
    ticks_d   = ticks_q;
    shift_d   = shift_q;
    sending_d = sending_q;
    level_d   = level_q;
    res       = '0;
    if (in_acc) begin
      if (in_i.operation == pdfs_pkg::OP_LOAD) begin
        if (!sending_q) begin
          // start with the lead-in high
          shift_d    = word_ext[WORD_BITS-1:0];
          sending_d  = 1'b1;
          phase_d    = '0;
          level_d    = 1'b1;
          ticks_d    = short_low_q;
          res.accepted = 1'b1;
        end
      end else if (sending_q) begin
        if (ticks_q <= pdfs_pkg::CfgW'(1)) begin
          if (phase_q >= GuardPh) begin
            sending_d      = 1'b0;
            level_d        = 1'b1;
            phase_d        = '0;
            ticks_d        = '0;
            res.frame_done = 1'b1;
          end else begin
            // advance to the next period: even periods high, odd low
            phase_d = next_ph;
            level_d = ~next_ph[0];
            if (next_ph == PhW'(1)) begin
              ticks_d = header_low_q;
            end else if (next_ph == PhW'(2)) begin
              ticks_d = header_high_q;
            end else if (next_ph == GuardPh) begin
              ticks_d = one_high_q;
            end else if (next_ph[0]) begin
              ticks_d = short_low_q;
            end else begin
              ticks_d = shift_q[WORD_BITS-1] ? one_high_q : zero_high_q;
              shift_d = shift_q << 1;
            end
          end
        end else begin
          ticks_d = ticks_q - pdfs_pkg::CfgW'(1);
        end
      end
    end
    res.line_level = level_d;
    res.busy_res   = sending_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= '0;
      ticks_q   <= '0;
      shift_q   <= '0;
      sending_q <= 1'b0;
      level_q   <= 1'b1;
    end else begin
      phase_q   <= phase_d;
      ticks_q   <= ticks_d;
      shift_q   <= shift_d;
      sending_q <= sending_d;
      level_q   <= level_d;
    end
  end

  pdfs_pkg::res_t out_res;

  pdfs_res_buf u_res_buf (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (in_acc),
    .push_data_i  (res),
    .push_ready_o (buf_ready),
    .pop_valid_o  (out_o.valid),
    .pop_ready_i  (out_o.ready),
    .pop_data_o   (out_res)
  );

  assign out_o.line_level = out_res.line_level;
  assign out_o.busy_res   = out_res.busy_res;
  assign out_o.accepted   = out_res.accepted;
  assign out_o.frame_done = out_res.frame_done;

endmodule

@@ src/pdfs_checker.sv @@
// ----------------------------------------------------------------------------
// pdfs_checker
// Port-level checks of the frame sender's result stream.
// ----------------------------------------------------------------------------
module pdfs_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic out_valid_i,
  input logic out_ready_i,
  input logic line_level_i,
  input logic busy_res_i,
  input logic accepted_i,
  input logic frame_done_i
);

  // a taken load starts the lead-in: busy with the line high
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && accepted_i |-> busy_res_i && line_level_i && !frame_done_i)
    else $error("accepted load did not start a frame");

  // the frame end leaves the line idle and high
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && frame_done_i |-> !busy_res_i && line_level_i)
    else $error("frame end did not return to idle");

  // idle line is always high
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !busy_res_i |-> line_level_i)
    else $error("line low while idle");

  // hold a stalled result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(line_level_i) &&
      $stable(busy_res_i) && $stable(accepted_i) && $stable(frame_done_i))
    else $error("stalled result changed");

endmodule

bind pulse_distance_frame_sender_top pdfs_checker u_pdfs_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .line_level_i (out_o.line_level),
  .busy_res_i   (out_o.busy_res),
  .accepted_i   (out_o.accepted),
  .frame_done_i (out_o.frame_done)
);

@@ test/pulse_distance_frame_sender_top_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pulse_distance_frame_sender_top_tb
// Drives tick and load requests into the frame sender and checks the line
// level, busy, load-taken and frame-done flags of every result against a
// cycle-free shadow of the frame timing. Runs directed frames at default
// and minimum durations, the latter behind one long receiver hold-off, then
// random frames with random idling on both channels, then maximum durations.
// ----------------------------------------------------------------------------
module pulse_distance_frame_sender_top_tb;

  localparam int unsigned WordBits   = 16;
  localparam int unsigned GuardSeg   = 4 + 2 * WordBits;
  localparam int unsigned HoldCycles = 300;
  localparam int unsigned StallLimit = 4000;

  typedef struct packed {
    logic                       op;
    logic [pdfs_pkg::DataW-1:0] word;
  } key_req_t;

  logic                         clk_i;
  logic                         rst_ni;
  logic                         cfg_we;
  logic [pdfs_pkg::CfgIdxW-1:0] cfg_idx;
  logic [pdfs_pkg::CfgW-1:0]    cfg_data;

  pdfs_in_if  req_if ();
  pdfs_out_if res_if ();

  pulse_distance_frame_sender_top #(
    .WORD_BITS(WordBits)
  ) DUT (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we),
    .cfg_idx_i (cfg_idx),
    .cfg_data_i(cfg_data),
    .in_i      (req_if),
    .out_o     (res_if)
  );

  // Shadow of the duration registers
  logic [pdfs_pkg::CfgW-1:0] dur_short    = pdfs_pkg::RST_SHORT_LOW;
  logic [pdfs_pkg::CfgW-1:0] dur_hdr_low  = pdfs_pkg::RST_HEADER_LOW;
  logic [pdfs_pkg::CfgW-1:0] dur_hdr_high = pdfs_pkg::RST_HEADER_HIGH;
  logic [pdfs_pkg::CfgW-1:0] dur_zero     = pdfs_pkg::RST_ZERO_HIGH;
  logic [pdfs_pkg::CfgW-1:0] dur_one      = pdfs_pkg::RST_ONE_HIGH;

  // Shadow of the frame state
  logic [5:0]                seg_idx   = '0;
  logic [pdfs_pkg::CfgW-1:0] seg_ticks = '0;
  logic [WordBits-1:0]       word_sr   = '0;
  logic                      tx_active = 1'b0;
  logic                      tx_level  = 1'b1;

  key_req_t         key_req_q[$];
  pdfs_pkg::res_t   line_state_q[$];
  key_req_t         drv_req;
  pdfs_pkg::res_t   got_state;
  pdfs_pkg::res_t   want_state;

  int  src_idle_pct = 16;
  int  snk_idle_pct = 74;
  bit  hold_rx      = 1'b0;
  int  hold_cnt     = 0;
  bit  req_taken    = 1'b0;
  int  idle_cycles  = 0;
  int  mismatches   = 0;
  int  queued_items = 0;

  // Enter frame segment s: set the level and load its duration
  task automatic enter_seg(input logic [5:0] s);
    logic [pdfs_pkg::CfgW-1:0] d;
    seg_idx  = s;
    tx_level = ~s[0];
    if (s == 6'd0) begin
      d = dur_short;
    end else if (s == 6'd1) begin
      d = dur_hdr_low;
    end else if (s == 6'd2) begin
      d = dur_hdr_high;
    end else if (s == 6'(GuardSeg)) begin
      d = dur_one;
    end else if (s[0]) begin
      d = dur_short;
    end else begin
      d = word_sr[WordBits-1] ? dur_one : dur_zero;
      word_sr = word_sr << 1;
    end
    seg_ticks = d;
  endtask

  task automatic advance_key_line(input logic op, input logic [pdfs_pkg::DataW-1:0] word,
                                  output pdfs_pkg::res_t r);
    r = '0;
    if (op == pdfs_pkg::OP_LOAD) begin
      if (!tx_active) begin
        word_sr   = word[WordBits-1:0];
        tx_active = 1'b1;
        enter_seg(6'd0);
        r.accepted = 1'b1;
      end
    end else if (tx_active) begin
      if (seg_ticks <= 1) begin
        if (seg_idx >= 6'(GuardSeg)) begin
          tx_active    = 1'b0;
          tx_level     = 1'b1;
          seg_idx      = '0;
          seg_ticks    = '0;
          r.frame_done = 1'b1;
        end else begin
          enter_seg(6'(seg_idx + 6'd1));
        end
      end else begin
        seg_ticks = seg_ticks - 1'b1;
      end
    end
    r.line_level = tx_level;
    r.busy_res   = tx_active;
  endtask

  task automatic check_bit(input string field, input logic want, input logic got);
    if (got !== want) begin
      $error("%s: expected %0b, got %0b", field, want, got);
      mismatches++;
    end
  endtask

  // A zero duration behaves as one tick
  function automatic int seg_len(input logic [pdfs_pkg::CfgW-1:0] d);
    return (d == 0) ? 1 : int'(d);
  endfunction

  function automatic int frame_len(input logic [pdfs_pkg::DataW-1:0] word);
    int n;
    n = 2 * seg_len(dur_short) + seg_len(dur_hdr_low) + seg_len(dur_hdr_high)
        + seg_len(dur_one);
    for (int b = 0; b < WordBits; b++) begin
      n += seg_len(dur_short) + seg_len(word[b] ? dur_one : dur_zero);
    end
    return n;
  endfunction

  task automatic push_req(input logic op, input logic [pdfs_pkg::DataW-1:0] word);
    key_req_q.push_back('{op: op, word: word});
    queued_items++;
  endtask

  // Queue a load and enough ticks to finish its frame; noisy frames get
  // refused loads mixed in and are sometimes cut short
  task automatic queue_frame(input logic [pdfs_pkg::DataW-1:0] word, input bit noisy);
    int n;
    n = frame_len(word);
    if (noisy && $urandom_range(7) == 0) begin
      n = $urandom_range(n);
    end
    push_req(pdfs_pkg::OP_LOAD, word);
    repeat (n) begin
      if (noisy && $urandom_range(9) == 0) begin
        push_req(pdfs_pkg::OP_LOAD, 16'($urandom_range(16'hFFFF)));
      end
      push_req(pdfs_pkg::OP_TICK, 16'($urandom_range(16'hFFFF)));
    end
    if (noisy) begin
      repeat ($urandom_range(3)) push_req(pdfs_pkg::OP_TICK, '0);
    end
  endtask

  task automatic run_random(input int target);
    int start;
    start = queued_items;
    while (queued_items - start < target) begin
      queue_frame(16'($urandom_range(16'hFFFF)), 1'b1);
    end
  endtask

  task automatic write_reg(input logic [pdfs_pkg::CfgIdxW-1:0] idx,
                           input logic [pdfs_pkg::CfgW-1:0] val);
    @(negedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(negedge clk_i);
    cfg_we <= 1'b0;
    case (idx)
      pdfs_pkg::REG_SHORT_LOW:   dur_short    = val;
      pdfs_pkg::REG_HEADER_LOW:  dur_hdr_low  = val;
      pdfs_pkg::REG_HEADER_HIGH: dur_hdr_high = val;
      pdfs_pkg::REG_ZERO_HIGH:   dur_zero     = val;
      pdfs_pkg::REG_ONE_HIGH:    dur_one      = val;
      default: ;
    endcase
  endtask

  task automatic write_all(input int s, input int hl, input int hh, input int z, input int o);
    write_reg(pdfs_pkg::REG_SHORT_LOW, 12'(s));
    write_reg(pdfs_pkg::REG_HEADER_LOW, 12'(hl));
    write_reg(pdfs_pkg::REG_HEADER_HIGH, 12'(hh));
    write_reg(pdfs_pkg::REG_ZERO_HIGH, 12'(z));
    write_reg(pdfs_pkg::REG_ONE_HIGH, 12'(o));
  endtask

  task automatic write_random(input int hi);
    write_all($urandom_range(hi, 1), $urandom_range(hi, 1), $urandom_range(hi, 1),
              $urandom_range(hi, 1), $urandom_range(hi, 1));
  endtask

  // Hold until every queued request is taken and every result has come
  task automatic drain();
    while (key_req_q.size() != 0 || req_if.valid || line_state_q.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (4) @(posedge clk_i);
  endtask

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Request driver
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      req_if.valid <= 1'b0;
    end else if (!req_if.valid || req_taken) begin
      if (key_req_q.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
        drv_req = key_req_q.pop_front();
        req_if.valid     <= 1'b1;
        req_if.operation <= drv_req.op;
        req_if.data_word <= drv_req.word;
      end else begin
        req_if.valid <= 1'b0;
      end
    end
  end

  // Result receiver, with one long hold-off on request
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
    end else if (hold_rx && hold_cnt < HoldCycles) begin
      res_if.ready <= 1'b0;
      hold_cnt <= hold_cnt + 1;
    end else begin
      res_if.ready <= ($urandom_range(99) >= snk_idle_pct);
    end
  end

  // Result check, prediction and watchdog
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      req_taken <= 1'b0;
      idle_cycles = 0;
    end else begin
      if (res_if.valid && res_if.ready) begin
        got_state = '{res_if.line_level, res_if.busy_res, res_if.accepted, res_if.frame_done};
        if (line_state_q.size() == 0) begin
          $error("result with no request outstanding");
          mismatches++;
        end else begin
          want_state = line_state_q.pop_front();
          check_bit("line_level", want_state.line_level, got_state.line_level);
          check_bit("busy_res", want_state.busy_res, got_state.busy_res);
          check_bit("accepted", want_state.accepted, got_state.accepted);
          check_bit("frame_done", want_state.frame_done, got_state.frame_done);
        end
      end
      if (req_if.valid && req_if.ready) begin
        advance_key_line(req_if.operation, req_if.data_word, want_state);
        line_state_q.push_back(want_state);
      end
      req_taken <= req_if.valid && req_if.ready;
      if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= StallLimit) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  initial begin
    rst_ni           = 1'b0;
    cfg_we           = 1'b0;
    cfg_idx          = '0;
    cfg_data         = '0;
    req_if.valid     = 1'b0;
    req_if.operation = pdfs_pkg::OP_TICK;
    req_if.data_word = '0;
    res_if.ready     = 1'b0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(posedge clk_i);

    // Default durations: idle tick, load, refused load, a few ticks
    push_req(pdfs_pkg::OP_TICK, 16'hFFFF);
    push_req(pdfs_pkg::OP_LOAD, 16'hFFFF);
    push_req(pdfs_pkg::OP_LOAD, 16'h0000);
    repeat (3) push_req(pdfs_pkg::OP_TICK, '0);
    drain();

    // Minimum durations with a zero high gap; unlisted indexes are ignored.
    // The frame above still runs out its lead-in at the old length.
    write_all(1, 1, 1, 0, 1);
    write_reg(3'd5, 12'hFFF);
    write_reg(3'd7, 12'h000);
    hold_rx = 1'b1;
    repeat (300) push_req(pdfs_pkg::OP_TICK, '0);
    queue_frame(16'h0000, 1'b0);
    queue_frame(16'hFFFF, 1'b0);
    queue_frame(16'h8001, 1'b0);
    drain();

    write_random(3);
    run_random(40);
    drain();

    src_idle_pct = 74;
    snk_idle_pct = 16;
    write_random(5);
    run_random(40);
    drain();

    src_idle_pct = 0;
    snk_idle_pct = 0;
    write_random(4);
    run_random(40);
    drain();

    // Maximum durations: the frame starts but does not finish
    write_all(4095, 4095, 4095, 4095, 4095);
    push_req(pdfs_pkg::OP_LOAD, 16'h5AA5);
    repeat (40) push_req(pdfs_pkg::OP_TICK, '0);
    push_req(pdfs_pkg::OP_LOAD, 16'h1234);
    drain();

    if (mismatches == 0 && line_state_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

@@ files.f @@
src/pdfs_pkg.sv
src/pdfs_in_if.sv
src/pdfs_out_if.sv
src/pdfs_res_buf.sv
src/pulse_distance_frame_sender_top.sv
src/pdfs_checker.sv
test/pulse_distance_frame_sender_top_tb.sv
